>>> sv/ebcsd_pkg.sv
// ============================================================================
// ebcsd_pkg
// Shared types and constants of the external bus chip-select decoder.
// ============================================================================
package ebcsd_pkg;

    localparam int unsigned CHIP_SELECTS_DEF = 6;

    localparam logic [31:0] UPPER_HALF  = 32'hffff_0000;
    localparam int unsigned GROUP_BYTES = 12;
    localparam logic [11:0] PORT_OFFSET = 12'h060;
    localparam logic [2:0]  REG_SIZE    = 3'd4;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_XFER  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SLOT_ADDRESS = 2'd0,
        SLOT_MASK    = 2'd1,
        SLOT_CONTROL = 2'd2
    } t_slot;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        mask_event;
        logic [2:0]  sel_index;
    } t_reg_resp;

    typedef struct packed {
        logic       hit;
        logic [2:0] sel_index;
    } t_match;

endpackage

>>> sv/ebcsd_regs.sv
// ============================================================================
// ebcsd_regs
// Chip-select register file with register access decode and mask events.
// ============================================================================
module ebcsd_regs #(
    parameter int unsigned CHIP_SELECTS = ebcsd_pkg::CHIP_SELECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [11:0]           i_offset,
    input  logic [2:0]            i_size,
    input  logic [31:0]           i_wdata,
    output ebcsd_pkg::t_reg_resp  o_resp,
    output logic [31:0]           o_sel_address [CHIP_SELECTS],
    output logic [31:0]           o_sel_mask    [CHIP_SELECTS]
);

    logic [31:0] r_address [CHIP_SELECTS];
    logic [31:0] r_mask    [CHIP_SELECTS];
    logic [31:0] r_control [CHIP_SELECTS];
    logic [31:0] r_port;

    logic                    access_ok;
    logic [CHIP_SELECTS-1:0] addr_hit;
    logic [CHIP_SELECTS-1:0] mask_hit;
    logic [CHIP_SELECTS-1:0] ctrl_hit;
    logic                    port_hit;

    always_comb begin
        access_ok = (i_size == ebcsd_pkg::REG_SIZE) && (i_offset[1:0] == 2'b00);
        port_hit  = access_ok && (i_offset == ebcsd_pkg::PORT_OFFSET);
        for (int g = 0; g < int'(CHIP_SELECTS); g++) begin
            addr_hit[g] = access_ok && (i_offset == 12'(ebcsd_pkg::GROUP_BYTES * g
                          + 4 * int'(ebcsd_pkg::SLOT_ADDRESS)));
            mask_hit[g] = access_ok && (i_offset == 12'(ebcsd_pkg::GROUP_BYTES * g
                          + 4 * int'(ebcsd_pkg::SLOT_MASK)));
            ctrl_hit[g] = access_ok && (i_offset == 12'(ebcsd_pkg::GROUP_BYTES * g
                          + 4 * int'(ebcsd_pkg::SLOT_CONTROL)));
        end
    end

    always_comb begin
        o_resp.hit         = port_hit || (|addr_hit) || (|mask_hit) || (|ctrl_hit);
        o_resp.read_data   = port_hit ? r_port : 32'd0;
        o_resp.mask_event  = (|mask_hit) && i_wdata[0];
        o_resp.sel_index   = 3'd0;
        for (int g = 0; g < int'(CHIP_SELECTS); g++) begin
            if (addr_hit[g]) begin
                o_resp.read_data = o_resp.read_data | r_address[g];
            end
            if (mask_hit[g]) begin
                o_resp.read_data = o_resp.read_data | r_mask[g];
                o_resp.sel_index = 3'(g);
            end
            if (ctrl_hit[g]) begin
                o_resp.read_data = o_resp.read_data | r_control[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < int'(CHIP_SELECTS); g++) begin
                r_address[g] <= 32'd0;
                r_mask[g]    <= 32'd0;
                r_control[g] <= 32'd0;
            end
            r_port <= 32'd0;
        end else if (i_wr_en) begin
            for (int g = 0; g < int'(CHIP_SELECTS); g++) begin
                if (addr_hit[g]) begin
                    r_address[g] <= i_wdata;
                end
                if (mask_hit[g]) begin
                    r_mask[g] <= i_wdata;
                end
                if (ctrl_hit[g]) begin
                    r_control[g] <= i_wdata;
                end
            end
            if (port_hit) begin
                r_port <= i_wdata;
            end
        end
    end

    assign o_sel_address = r_address;
    assign o_sel_mask    = r_mask;

endmodule

>>> sv/ebcsd_match.sv
// ============================================================================
// ebcsd_match
// Parallel address compare of all chip selects with first-match priority.
// ============================================================================
module ebcsd_match #(
    parameter int unsigned CHIP_SELECTS = ebcsd_pkg::CHIP_SELECTS_DEF
) (
    input  logic [31:0]        i_address,
    input  logic [31:0]        i_sel_address [CHIP_SELECTS],
    input  logic [31:0]        i_sel_mask    [CHIP_SELECTS],
    output ebcsd_pkg::t_match  o_match
);

    logic [CHIP_SELECTS-1:0] hit;

    always_comb begin
        for (int g = 0; g < int'(CHIP_SELECTS); g++) begin
            hit[g] = i_sel_mask[g][0] &&
                     (((i_address ^ i_sel_address[g]) & ~i_sel_mask[g]
                       & ebcsd_pkg::UPPER_HALF) == 32'd0);
        end
    end

    always_comb begin
        o_match.hit       = |hit;
        o_match.sel_index = 3'd0;
        for (int g = int'(CHIP_SELECTS) - 1; g >= 0; g--) begin
            if (hit[g]) begin
                o_match.sel_index = 3'(g);
            end
        end
    end

endmodule

>>> sv/external_bus_chip_select_decoder_unit.sv
// ============================================================================
// external_bus_chip_select_decoder_unit
// Chip-select register file and address decoder of an external bus interface.
// ============================================================================
// The input channel carries register reads, register writes and bus transfers.
// Each transfer is captured in an input register, decoded against the
// chip-select groups, and its single result is held in an output register
// until the receiver takes it. The result moves from the input register into
// the output register, and the output transfer is made from there; one item
// is taken per cycle while the receiver keeps up.
// Register writes update the file as the item moves into the output register,
// so the next item already sees the new contents.
// When the receiver stalls, the output register holds its result and the
// input register holds one more item; input ready drops only when both are
// full and the output is not being taken.
// The configuration channel sets the module clock enable. While it is low,
// every item returns a failed result and no event. Reset clears all chip-select
// registers, the port control word and the clock enable, and empties both
// stages. The configuration channel is always ready.
// ============================================================================
module external_bus_chip_select_decoder_unit #(
    parameter int unsigned CHIP_SELECTS = ebcsd_pkg::CHIP_SELECTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_register_offset,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_bus_address,
    input  logic [31:0] i_write_data,
    input  logic        i_is_write,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [31:0] o_read_data,
    output logic        o_event_valid,
    output logic [2:0]  o_event_chip_select,
    output logic [31:0] o_event_data,
    output logic [2:0]  o_event_size,
    output logic        o_event_is_write
);

    logic        r_clk_en;

    logic        r_s1_valid;
    logic [1:0]  r_kind;
    logic [11:0] r_offset;
    logic [2:0]  r_size;
    logic [31:0] r_address;
    logic [31:0] r_data;
    logic        r_is_write;

    logic        r_out_valid;
    logic        r_ok;
    logic [31:0] r_read_data;
    logic        r_ev_valid;
    logic [2:0]  r_ev_cs;
    logic [31:0] r_ev_data;
    logic [2:0]  r_ev_size;
    logic        r_ev_is_write;

    logic        n_ok;
    logic [31:0] n_read_data;
    logic        n_ev_valid;
    logic [2:0]  n_ev_cs;
    logic [31:0] n_ev_data;
    logic [2:0]  n_ev_size;
    logic        n_ev_is_write;

    logic        s1_advance;
    logic        in_fire;
    logic        reg_wr_en;

    ebcsd_pkg::t_reg_resp reg_resp;
    ebcsd_pkg::t_match    match;
    logic [31:0]          sel_address [CHIP_SELECTS];
    logic [31:0]          sel_mask    [CHIP_SELECTS];

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_fire    = i_in_valid && o_in_ready;
    assign reg_wr_en  = s1_advance && r_clk_en && (r_kind == ebcsd_pkg::KIND_WRITE);

    assign o_cfg_ready = 1'b1;

    ebcsd_regs #(
        .CHIP_SELECTS (CHIP_SELECTS)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (reg_wr_en),
        .i_offset      (r_offset),
        .i_size        (r_size),
        .i_wdata       (r_data),
        .o_resp        (reg_resp),
        .o_sel_address (sel_address),
        .o_sel_mask    (sel_mask)
    );

    ebcsd_match #(
        .CHIP_SELECTS (CHIP_SELECTS)
    ) u_match (
        .i_address     (r_address),
        .i_sel_address (sel_address),
        .i_sel_mask    (sel_mask),
        .o_match       (match)
    );

    always_comb begin
        n_ok          = 1'b0;
        n_read_data   = 32'd0;
        n_ev_valid    = 1'b0;
        n_ev_cs       = 3'd0;
        n_ev_data     = 32'd0;
        n_ev_size     = 3'd0;
        n_ev_is_write = 1'b0;
        if (r_clk_en) begin
            case (r_kind)
                ebcsd_pkg::KIND_READ: begin
                    n_ok        = reg_resp.hit;
                    n_read_data = reg_resp.hit ? reg_resp.read_data : 32'd0;
                end
                ebcsd_pkg::KIND_WRITE: begin
                    n_ok = reg_resp.hit;
                    if (reg_resp.mask_event) begin
                        n_ev_valid = 1'b1;
                        n_ev_cs    = reg_resp.sel_index;
                        n_ev_data  = r_data;
                    end
                end
                ebcsd_pkg::KIND_XFER: begin
                    if ((r_size inside {3'd1, 3'd2, 3'd4}) && match.hit) begin
                        n_ok          = 1'b1;
                        n_ev_valid    = 1'b1;
                        n_ev_cs       = match.sel_index;
                        n_ev_data     = r_data;
                        n_ev_size     = r_size;
                        n_ev_is_write = r_is_write;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clk_en <= i_cfg_data;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= i_kind;
            r_offset   <= i_register_offset;
            r_size     <= i_access_size;
            r_address  <= i_bus_address;
            r_data     <= i_write_data;
            r_is_write <= i_is_write;
        end
        if (s1_advance) begin
            r_ok          <= n_ok;
            r_read_data   <= n_read_data;
            r_ev_valid    <= n_ev_valid;
            r_ev_cs       <= n_ev_cs;
            r_ev_data     <= n_ev_data;
            r_ev_size     <= n_ev_size;
            r_ev_is_write <= n_ev_is_write;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ok                = r_ok;
    assign o_read_data         = r_read_data;
    assign o_event_valid       = r_ev_valid;
    assign o_event_chip_select = r_ev_cs;
    assign o_event_data        = r_ev_data;
    assign o_event_size        = r_ev_size;
    assign o_event_is_write    = r_ev_is_write;

    a_event_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_valid) |-> r_ok)
        else $error("Event reported on a failed result.");

    a_no_event_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ev_valid) |->
        (r_ev_size == 3'd0 && r_ev_cs == 3'd0 && r_ev_data == 32'd0 && !r_ev_is_write))
        else $error("Event fields set without an event.");

    a_gated_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && !r_clk_en) |=> (r_out_valid && !r_ok && !r_ev_valid))
        else $error("Result succeeded while the module clock was gated.");

    a_cs_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_valid) |-> ({1'b0, r_ev_cs} < 4'(CHIP_SELECTS)))
        else $error("Event chip select out of range.");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> r_s1_valid)
        else $error("Input stage lost an item during a stall.");

endmodule
